// ===== hw/rtl/bcomp_pkg.sv =====
// Package for the barometer compensation pipeline.
// Holds stage counts, register indexes, formula constants and split-multiply helpers.
// No dependencies.
package bcomp_pkg;

    localparam int DIV_STEPS = 64;
    // Stages before the divider, divider load, divider steps, sign fix, post-divide stages
    localparam int LAT = 18 + DIV_STEPS;
    localparam int ST_TEMP = 4;
    localparam int ST_DIV0 = 11;
    localparam int ST_QFIX = ST_DIV0 + DIV_STEPS + 1;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LOW  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HIGH = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_NINE = 8'd3;

    localparam logic [63:0] OFFSET_FINE = 64'd128000;
    localparam logic [20:0] RAW_BASE    = 21'd1048576;
    localparam logic [63:0] PRESS_SCALE = 64'd3125;
    localparam logic [31:0] TEMP_MUL    = 32'd5;
    localparam logic [31:0] TEMP_RND    = 32'd128;
    localparam logic [63:0] DEN_BIAS    = 64'h0000_8000_0000_0000;

    // Partial products of a 64x64 multiply that keeps the low 64 bits
    typedef struct packed {
        logic [63:0] ll;
        logic [31:0] lh;
        logic [31:0] hl;
    } t_part;

    function automatic t_part mul_part(input logic [63:0] a, input logic [63:0] b);
        t_part       p;
        logic [63:0] c1;
        logic [63:0] c2;
        c1   = a[31:0] * b[63:32];
        c2   = a[63:32] * b[31:0];
        p.ll = a[31:0] * b[31:0];
        p.lh = c1[31:0];
        p.hl = c2[31:0];
        return p;
    endfunction

    function automatic logic [63:0] mul_sum(input t_part p);
        logic [31:0] s;
        s = p.lh + p.hl;
        return p.ll + {s, 32'h0};
    endfunction

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

endpackage

// ===== hw/rtl/barometer_compensation.sv =====
// Barometer compensation: 82 register stages; one transaction accepted per cycle, back to back,
// while the output is not stalled.
// Temperature path in stages 0-4, pressure polynomial in split 32-bit multiplies,
// a 64-step restoring divider at one quotient bit per stage, then the final terms.
// A stalled output freezes every stage; nothing is dropped or repeated.
// Synchronous active-low reset clears valid bits and coefficients to zero.
// Depends on bcomp_pkg.
module barometer_compensation
    import bcomp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [19:0]          i_raw_temperature,
    input  logic [19:0]          i_raw_pressure,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [31:0]   o_temperature_centi,
    output logic [31:0]          o_pressure_q24_8,
    output logic                 o_pressure_invalid
);

    logic [47:0] r_cfg_t;
    logic [63:0] r_cfg_pl;
    logic [63:0] r_cfg_ph;
    logic [15:0] r_cfg_p9;

    logic [LAT-1:0] r_vld;
    logic           en;

    assign en      = !r_vld[LAT-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_t  <= '0;
            r_cfg_pl <= '0;
            r_cfg_ph <= '0;
            r_cfg_p9 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TEMP:       r_cfg_t  <= i_cfg_data[47:0];
                CFG_PRESS_LOW:  r_cfg_pl <= i_cfg_data;
                CFG_PRESS_HIGH: r_cfg_ph <= i_cfg_data;
                CFG_PRESS_NINE: r_cfg_p9 <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Coefficients
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [63:0]        p1, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = r_cfg_t[15:0];
    assign t2 = $signed(r_cfg_t[31:16]);
    assign t3 = $signed(r_cfg_t[47:32]);
    assign p1 = {48'h0, r_cfg_pl[15:0]};
    assign p2 = sx16(r_cfg_pl[31:16]);
    assign p3 = sx16(r_cfg_pl[47:32]);
    assign p4 = sx16(r_cfg_pl[63:48]);
    assign p5 = sx16(r_cfg_ph[15:0]);
    assign p6 = sx16(r_cfg_ph[31:16]);
    assign p7 = sx16(r_cfg_ph[47:32]);
    assign p8 = sx16(r_cfg_ph[63:48]);
    assign p9 = sx16(r_cfg_p9);

    // Temperature stages
    logic signed [17:0] r_d1;
    logic signed [16:0] r_d2;
    logic signed [33:0] r_m1;
    logic signed [33:0] r_sq;
    logic [31:0]        r_a1;
    logic signed [35:0] r_m2;
    logic [31:0]        r_fine;
    logic [63:0]        r_x;
    logic [20:0]        r_nb [0:8];
    logic [31:0]        r_tmp [ST_TEMP:LAT-1];

    logic [31:0]        sq_sh;
    logic [31:0]        fine5;
    logic [31:0]        temp_v;
    logic [31:0]        a2;

    assign sq_sh  = 32'($signed(r_sq[31:0]) >>> 12);
    assign a2     = 32'($signed(r_m2[31:0]) >>> 14);
    assign fine5  = r_fine * TEMP_MUL + TEMP_RND;
    assign temp_v = 32'($signed(fine5) >>> 8);

    // Pressure stages ahead of the divider
    t_part       r_pxx, r_pp5, r_pp2, r_pxx6, r_pxx3, r_pd;
    logic [63:0] r_xx, r_xp5, r_xp2, r_xp5b, r_xp2b;
    logic [63:0] r_y, r_dp, r_t, r_den, r_num;
    logic [63:0] y_v, dp_v;

    assign y_v  = mul_sum(r_pxx6) + (r_xp5b << 17) + (p4 << 35);
    assign dp_v = 64'($signed(mul_sum(r_pxx3)) >>> 8) + (r_xp2b << 12) + DEN_BIAS;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1    <= $signed({1'b0, i_raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
            r_d2    <= $signed({1'b0, i_raw_temperature[19:4]}) - $signed({1'b0, t1});
            r_nb[0] <= RAW_BASE - {1'b0, i_raw_pressure};
            for (int k = 1; k < 9; k++) begin
                r_nb[k] <= r_nb[k-1];
            end
            r_m1   <= r_d1 * t2;
            r_sq   <= r_d2 * r_d2;
            r_a1   <= 32'($signed(r_m1[31:0]) >>> 11);
            r_m2   <= $signed(sq_sh[19:0]) * t3;
            r_fine <= r_a1 + a2;
            r_tmp[ST_TEMP] <= temp_v;
            for (int k = ST_TEMP + 1; k < LAT; k++) begin
                r_tmp[k] <= r_tmp[k-1];
            end
            r_x    <= {{32{r_fine[31]}}, r_fine} - OFFSET_FINE;
            r_pxx  <= mul_part(r_x, r_x);
            r_pp5  <= mul_part(r_x, p5);
            r_pp2  <= mul_part(r_x, p2);
            r_xx   <= mul_sum(r_pxx);
            r_xp5  <= mul_sum(r_pp5);
            r_xp2  <= mul_sum(r_pp2);
            r_pxx6 <= mul_part(r_xx, p6);
            r_pxx3 <= mul_part(r_xx, p3);
            r_xp5b <= r_xp5;
            r_xp2b <= r_xp2;
            r_y    <= y_v;
            r_dp   <= dp_v;
            r_pd   <= mul_part(r_dp, p1);
            r_t    <= {12'h0, r_nb[8], 31'h0} - r_y;
            r_den  <= 64'($signed(mul_sum(r_pd)) >>> 33);
            r_num  <= r_t * PRESS_SCALE;
        end
    end

    // Divider: load magnitudes, then one quotient bit per stage
    logic [63:0] r_dv_rem [0:DIV_STEPS];
    logic [63:0] r_dv_dvd [0:DIV_STEPS];
    logic [63:0] r_dv_ub  [0:DIV_STEPS];
    logic        r_dv_neg [0:DIV_STEPS];
    logic        r_bad    [ST_DIV0:LAT-1];
    logic [63:0] n_dv_rem [1:DIV_STEPS];
    logic [63:0] n_dv_dvd [1:DIV_STEPS];
    logic        den_zero;

    assign den_zero = (r_den == 64'h0);

    always_comb begin
        logic [64:0] tr;
        logic        ge;
        for (int k = 0; k < DIV_STEPS; k++) begin
            tr = {r_dv_rem[k], r_dv_dvd[k][63]};
            ge = (tr >= {1'b0, r_dv_ub[k]});
            n_dv_rem[k+1] = ge ? 64'(tr - {1'b0, r_dv_ub[k]}) : tr[63:0];
            n_dv_dvd[k+1] = {r_dv_dvd[k][62:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_rem[0] <= '0;
            r_dv_dvd[0] <= r_num[63] ? 64'h0 - r_num : r_num;
            r_dv_ub[0]  <= den_zero ? 64'h1 : (r_den[63] ? 64'h0 - r_den : r_den);
            r_dv_neg[0] <= r_num[63] ^ r_den[63];
            r_bad[ST_DIV0] <= den_zero;
            for (int k = ST_DIV0 + 1; k < LAT; k++) begin
                r_bad[k] <= r_bad[k-1];
            end
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_dv_rem[k] <= n_dv_rem[k];
                r_dv_dvd[k] <= n_dv_dvd[k];
                r_dv_ub[k]  <= r_dv_ub[k-1];
                r_dv_neg[k] <= r_dv_neg[k-1];
            end
        end
    end

    // Post-divide stages
    logic [63:0] r_q [ST_QFIX:ST_QFIX+3];
    t_part       r_pqq, r_pq8, r_pq9;
    logic [63:0] r_qq, r_p8q, r_yq, r_v;
    logic [63:0] q13, out_v;

    assign q13   = 64'($signed(r_q[ST_QFIX]) >>> 13);
    assign out_v = 64'($signed(r_v) >>> 8) + (p7 << 4);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q[ST_QFIX] <= r_dv_neg[DIV_STEPS] ? 64'h0 - r_dv_dvd[DIV_STEPS]
                                                 : r_dv_dvd[DIV_STEPS];
            for (int k = ST_QFIX + 1; k <= ST_QFIX + 3; k++) begin
                r_q[k] <= r_q[k-1];
            end
            r_pqq <= mul_part(q13, q13);
            r_pq8 <= mul_part(p8, r_q[ST_QFIX]);
            r_qq  <= mul_sum(r_pqq);
            r_p8q <= mul_sum(r_pq8);
            r_pq9 <= mul_part(p9, r_qq);
            r_yq  <= 64'($signed(r_p8q) >>> 19);
            r_v   <= 64'($signed(mul_sum(r_pq9)) >>> 25) + r_q[ST_QFIX+3] + r_yq;
            o_pressure_q24_8 <= r_bad[LAT-2] ? 32'h0 : out_v[31:0];
        end
    end

    assign o_temperature_centi = $signed(r_tmp[LAT-1]);
    assign o_pressure_invalid  = r_bad[LAT-1];

    // Checks
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pressure_invalid |-> o_pressure_q24_8 == 32'h0)
        else $error("invalid pressure not forced to zero");

    a_rem_lt_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_DIV0 + DIV_STEPS] |-> r_dv_rem[DIV_STEPS] < r_dv_ub[DIV_STEPS])
        else $error("divider remainder not below divisor");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during stall");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> r_vld == '0)
        else $error("valid bits not cleared by reset");

endmodule

// ===== tb/tb_barometer_compensation.sv =====
// Self-checking testbench for barometer_compensation: directed table, extreme coefficients, then random sample pairs.
// Predicts compensated temperature and pressure in 32/64-bit wrap arithmetic.
// Depends on bcomp_pkg and the barometer_compensation RTL.
module tb_barometer_compensation;
    import bcomp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
        logic               pressure_invalid;
    } t_comp_sample;

    typedef struct {
        logic [19:0]  raw_t;
        logic [19:0]  raw_p;
        bit           typed;
        t_comp_sample want;
    } t_sample_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [19:0] i_raw_temperature = '0;
    logic [19:0] i_raw_pressure = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic signed [31:0] o_temperature_centi;
    logic [31:0] o_pressure_q24_8;
    logic        o_pressure_invalid;

    barometer_compensation uut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow coefficients
    logic [47:0] coef_temp;
    logic [63:0] coef_press_lo, coef_press_hi;
    logic [15:0] coef_p9;

    t_comp_sample pending_results[$];
    int  errors = 0;
    int  n_checked = 0;
    int  n_invalid = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    longint cycles = 0;
    localparam longint CYCLE_LIMIT = 2_000_000;

    function automatic logic [31:0] asr32(logic [31:0] x, int s);
        return $signed(x) >>> s;
    endfunction

    function automatic logic [63:0] asr64(logic [63:0] x, int s);
        return $signed(x) >>> s;
    endfunction

    function automatic t_comp_sample compensate(logic [19:0] rt, logic [19:0] rp);
        t_comp_sample r;
        logic [31:0] t1, t2, t3, d1, a1, d2, fine;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] x, y, den, num, q, ua, ub, xx;
        logic [63:0] press;
        t1 = {16'h0, coef_temp[15:0]};
        t2 = {{16{coef_temp[31]}}, coef_temp[31:16]};
        t3 = {{16{coef_temp[47]}}, coef_temp[47:32]};
        p1 = {48'h0, coef_press_lo[15:0]};
        p2 = {{48{coef_press_lo[31]}}, coef_press_lo[31:16]};
        p3 = {{48{coef_press_lo[47]}}, coef_press_lo[47:32]};
        p4 = {{48{coef_press_lo[63]}}, coef_press_lo[63:48]};
        p5 = {{48{coef_press_hi[15]}}, coef_press_hi[15:0]};
        p6 = {{48{coef_press_hi[31]}}, coef_press_hi[31:16]};
        p7 = {{48{coef_press_hi[47]}}, coef_press_hi[47:32]};
        p8 = {{48{coef_press_hi[63]}}, coef_press_hi[63:48]};
        p9 = {{48{coef_p9[15]}}, coef_p9};
        d1 = {15'h0, rt[19:3]} - (t1 << 1);
        a1 = asr32(d1 * t2, 11);
        d2 = {16'h0, rt[19:4]} - t1;
        fine = a1 + asr32(asr32(d2 * d2, 12) * t3, 14);
        r.temperature_centi = asr32(fine * 32'd5 + 32'd128, 8);
        x = {{32{fine[31]}}, fine} - 64'd128000;
        xx = x * x;
        y = xx * p6 + ((x * p5) << 17) + (p4 << 35);
        den = asr64(xx * p3, 8) + ((x * p2) << 12);
        den = asr64((64'h0000_8000_0000_0000 + den) * p1, 33);
        press = '0;
        r.pressure_invalid = (den == 0);
        if (den != 0) begin
            num = 64'd1048576 - {44'h0, rp};
            num = ((num << 31) - y) * 64'd3125;
            ua = num[63] ? -num : num;
            ub = den[63] ? -den : den;
            q = ua / ub;
            if (num[63] != den[63]) q = -q;
            x = asr64(p9 * asr64(q, 13) * asr64(q, 13), 25);
            y = asr64(p8 * q, 19);
            press = asr64(q + x + y, 8) + (p7 << 4);
        end
        r.pressure_q24_8 = press[31:0];
        return r;
    endfunction

    // one write per call; the write enable is dropped again before the task returns
    task automatic write_coeff(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TEMP:       coef_temp = val[47:0];
            CFG_PRESS_LOW:  coef_press_lo = val;
            CFG_PRESS_HIGH: coef_press_hi = val;
            CFG_PRESS_NINE: coef_p9 = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // drive one transaction; hold valid until accepted, drop it only while idling
    task automatic send_sample(logic [19:0] rt, logic [19:0] rp, bit typed, t_comp_sample w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_raw_temperature <= rt;
        i_raw_pressure    <= rp;
        pending_results.push_back(typed ? w : compensate(rt, rp));
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_comp_sample w;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                w = pending_results.pop_front();
                n_checked++;
                if (o_pressure_invalid) n_invalid++;
                if (o_temperature_centi !== w.temperature_centi) begin
                    $error("temperature_centi exp %0d got %0d",
                           w.temperature_centi, o_temperature_centi);
                    errors++;
                end
                if (o_pressure_q24_8 !== w.pressure_q24_8) begin
                    $error("pressure_q24_8 exp %0h got %0h", w.pressure_q24_8,
                           o_pressure_q24_8);
                    errors++;
                end
                if (o_pressure_invalid !== w.pressure_invalid) begin
                    $error("pressure_invalid exp %0b got %0b", w.pressure_invalid,
                           o_pressure_invalid);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // plausible calibration (fully random when extreme is set): positive T1/P1 and small-ish signed terms
    task automatic load_random_coeffs(bit extreme);
        if (extreme) begin
            write_coeff(CFG_TEMP, {16'h0, 48'(rand64())});
            write_coeff(CFG_PRESS_LOW, rand64());
            write_coeff(CFG_PRESS_HIGH, rand64());
            write_coeff(CFG_PRESS_NINE, {48'h0, 16'($urandom())});
        end else begin
            write_coeff(CFG_TEMP, {16'h0, 16'($urandom_range(100, 50)),
                                   16'($urandom_range(27000, 25000)),
                                   16'($urandom_range(28000, 27000))});
            write_coeff(CFG_PRESS_LOW, {16'($urandom_range(9000, 2000)),
                                        16'($urandom_range(4000, 1000)),
                                        16'(-$urandom_range(11000, 10000)),
                                        16'($urandom_range(38000, 34000))});
            write_coeff(CFG_PRESS_HIGH, {16'(-$urandom_range(15000, 10000)),
                                         16'($urandom_range(16000, 14000)),
                                         16'(-$urandom_range(8, 0)),
                                         16'($urandom_range(300, 0))});
            write_coeff(CFG_PRESS_NINE, {48'h0, 16'($urandom_range(7000, 5000))});
        end
    endtask

    t_sample_row directed[$];

    initial begin
        t_sample_row row;
        t_comp_sample zero_res;
        coef_temp = '0; coef_press_lo = '0; coef_press_hi = '0; coef_p9 = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        i_ready <= 1'b1;
        @(posedge i_clk);

        // after reset every coefficient is zero: temperature 0, divisor 0
        zero_res = '{temperature_centi: 32'sd0, pressure_q24_8: 32'd0, pressure_invalid: 1'b1};
        directed.push_back('{20'h00000, 20'h00000, 1'b1, zero_res});
        directed.push_back('{20'hFFFFF, 20'hFFFFF, 1'b1, zero_res});
        directed.push_back('{20'hAAAAA, 20'h55555, 1'b1, zero_res});
        foreach (directed[i])
            send_sample(directed[i].raw_t, directed[i].raw_p, directed[i].typed, directed[i].want);
        drain();

        // typical calibration, extremes of the raw fields
        directed.delete();
        load_random_coeffs(1'b0);
        write_coeff(8'd4, rand64()); // out-of-range index: ignored
        write_coeff(8'hFF, rand64());
        for (int k = 0; k < 12; k++) begin
            row.raw_t = (k % 3 == 0) ? 20'h0 : (k % 3 == 1) ? 20'hFFFFF : 20'($urandom());
            row.raw_p = (k % 4 == 0) ? 20'h0 : (k % 4 == 1) ? 20'hFFFFF : 20'($urandom());
            row.typed = 1'b0;
            row.want  = '0;
            directed.push_back(row);
        end
        foreach (directed[i])
            send_sample(directed[i].raw_t, directed[i].raw_p, directed[i].typed, directed[i].want);
        drain();

        // extreme coefficients: all ones (P9 largest positive), most negative, P1 zero (divisor zero)
        write_coeff(CFG_TEMP, 64'hFFFF_FFFF_FFFF);
        write_coeff(CFG_PRESS_LOW, '1);
        write_coeff(CFG_PRESS_HIGH, '1);
        write_coeff(CFG_PRESS_NINE, 64'h7FFF);
        for (int k = 0; k < 4; k++) send_sample(20'($urandom()), 20'($urandom()), 1'b0, '0);
        drain();
        write_coeff(CFG_TEMP, 64'h8000_8000_0000);
        write_coeff(CFG_PRESS_LOW, 64'h8000_8000_8000_FFFF);
        write_coeff(CFG_PRESS_HIGH, 64'h8000_8000_8000_8000);
        write_coeff(CFG_PRESS_NINE, 64'h8000);
        for (int k = 0; k < 4; k++) send_sample(20'($urandom()), 20'($urandom()), 1'b0, '0);
        drain();
        write_coeff(CFG_PRESS_LOW, 64'h1234_5678_9ABC_0000);
        send_sample(20'hFFFFF, 20'h00000, 1'b0, '0);
        drain();

        // random phases: mostly realistic calibrations, some fully random
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 48 : 0;
            recv_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 21 : 0;
            for (int blk = 0; blk < 6; blk++) begin
                load_random_coeffs(blk == 5);
                for (int k = 0; k < 95; k++) begin
                    if (blk < 5 && $urandom_range(3) != 0)
                        send_sample(20'($urandom_range(600000, 400000)),
                                    20'($urandom_range(500000, 250000)), 1'b0, '0);
                    else
                        send_sample(20'($urandom()), 20'($urandom()), 1'b0, '0);
                end
                drain();
            end
        end
        recv_idle_pct = 0;
        drain();

        $display("checked %0d compensated samples, %0d with zero pressure divisor",
                 n_checked, n_invalid);
        $display("covered reset, extreme and random calibrations under three stall mixes");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/bcomp_pkg.sv
hw/rtl/barometer_compensation.sv
tb/tb_barometer_compensation.sv
